// ----- sv/pm0_pkg.sv -----
// Package: PM/0 stack machine types and codes.
package pm0_pkg;

  localparam logic [3:0] OP_LIT = 4'd1;
  localparam logic [3:0] OP_OPR = 4'd2;
  localparam logic [3:0] OP_LOD = 4'd3;
  localparam logic [3:0] OP_STO = 4'd4;
  localparam logic [3:0] OP_CAL = 4'd5;
  localparam logic [3:0] OP_INC = 4'd6;
  localparam logic [3:0] OP_JMP = 4'd7;
  localparam logic [3:0] OP_JPC = 4'd8;
  localparam logic [3:0] OP_SYS = 4'd9;

  localparam logic [31:0] OPR_RTN = 32'd0;
  localparam logic [31:0] OPR_NEG = 32'd1;
  localparam logic [31:0] OPR_ADD = 32'd2;
  localparam logic [31:0] OPR_SUB = 32'd3;
  localparam logic [31:0] OPR_MUL = 32'd4;
  localparam logic [31:0] OPR_DIV = 32'd5;
  localparam logic [31:0] OPR_EQL = 32'd6;
  localparam logic [31:0] OPR_NEQ = 32'd7;
  localparam logic [31:0] OPR_LSS = 32'd8;
  localparam logic [31:0] OPR_LEQ = 32'd9;
  localparam logic [31:0] OPR_GTR = 32'd10;
  localparam logic [31:0] OPR_GEQ = 32'd11;

  localparam logic [31:0] SYS_OUT = 32'd1;
  localparam logic [31:0] SYS_IN  = 32'd2;
  localparam logic [31:0] SYS_HLT = 32'd3;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_HALT = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  localparam int RESET_BP = 480;
  localparam int RESET_SP = 481;

  // address select for the memory port
  typedef enum logic [3:0] {
    A_SP     = 4'd0,
    A_SP_P1  = 4'd1,
    A_SP_M1  = 4'd2,
    A_SP_M2  = 4'd3,
    A_SP_M3  = 4'd4,
    A_BP_M1  = 4'd5,
    A_BP_M2  = 4'd6,
    A_WALK   = 4'd7,
    A_FRAME  = 4'd8,
    A_CLR    = 4'd9
  } addr_sel_t;

  typedef enum logic [2:0] {
    D_OPA  = 3'd0,
    D_ALU  = 3'd1,
    D_BP   = 3'd2,
    D_PC   = 3'd3,
    D_WALK = 3'd4,
    D_READ = 3'd5,
    D_OPND = 3'd6,
    D_ZERO = 3'd7
  } data_sel_t;

  typedef struct packed {
    logic      capture;   // latch input transaction
    addr_sel_t addr;
    logic      rd;
    logic      wr;
    data_sel_t wdata;
    logic      ld_a;      // capture read data into A
    logic      ld_b;      // capture read data into B
    logic      ld_walk;   // walk pointer <= wrapped read data
    logic      walk_init; // walk pointer <= BP
    logic      lvl_dec;
    logic      clr_inc;
    logic      div_start;
    logic      commit;    // update pointers and form result
  } pm0_cmd_t;

  typedef struct packed {
    logic [3:0] opcode;
    logic       lvl_zero;
    logic       halted;
    logic       clr_done;
    logic       div_done;
    logic       opr_rtn;
    logic       opr_neg;
    logic       opr_bin;
    logic       opr_div;
    logic       sys_out;
    logic       sys_in;
  } pm0_stat_t;

endpackage

// ----- sv/pm0_ram.sv -----
// Generic single-port RAM with registered read.
module pm0_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- sv/pm0_div.sv -----
// Iterative signed 32-bit divider, one quotient bit per cycle.
module pm0_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  logic [31:0] rem, quo, dvs;
  logic [5:0]  cnt;
  logic        busy, neg;
  logic [32:0] trial;
  logic [31:0] rem_sh;

  assign rem_sh = {rem[30:0], quo[31]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dvs};
  assign quotient = neg ? (32'd0 - quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        rem  <= '0;
        quo  <= dividend[31] ? (32'd0 - dividend) : dividend;
        dvs  <= divisor[31] ? (32'd0 - divisor) : divisor;
        neg  <= dividend[31] ^ divisor[31];
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- sv/pm0_datapath.sv -----
// Datapath: pointers, stack memory, ALU and result register.
module pm0_datapath #(
  parameter int MEM_DEPTH = 512,
  parameter int MAX_LEVEL = 15,
  localparam int AW = $clog2(MEM_DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  pm0_pkg::pm0_cmd_t  cmd,
  output pm0_pkg::pm0_stat_t stat,
  input  logic [3:0]         in_opcode,
  input  logic [3:0]         in_level,
  input  logic [31:0]        in_operand,
  input  logic [31:0]        in_read,
  output logic [8:0]         r_pc,
  output logic [8:0]         r_bp,
  output logic [8:0]         r_sp,
  output logic               r_pvalid,
  output logic [31:0]        r_pvalue,
  output logic [1:0]         r_status
);
  localparam logic [AW-1:0] RBP = AW'(pm0_pkg::RESET_BP % MEM_DEPTH);
  localparam logic [AW-1:0] RSP = AW'(pm0_pkg::RESET_SP % MEM_DEPTH);
  localparam int LW = $clog2(MAX_LEVEL + 1) > 4 ? $clog2(MAX_LEVEL + 1) : 4;

  logic [AW-1:0] pc, bp, sp, walk, clr;
  logic          halted, clr_done;
  logic [3:0]    opcode;
  logic [31:0]   operand, rdv;
  logic [LW-1:0] lvl;
  logic [31:0]   a, b;
  logic [AW-1:0] addr, frame, m_w, pc3;
  logic [31:0]   wdata, rdata, alu, quo;
  logic          div_done, sa_lt;

  assign m_w  = operand[AW-1:0];
  assign pc3  = pc + AW'(3);
  assign frame = walk - m_w;
  assign sa_lt = $signed(a) < $signed(b);

  pm0_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_ram (
    .clk(clk), .we(cmd.wr), .addr(addr), .wdata(wdata), .rdata(rdata));

  // divisor comes straight from the read port; b loads on the same edge
  pm0_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(a), .divisor(rdata),
    .done(div_done), .quotient(quo));

  always_comb begin
    case (cmd.addr)
      pm0_pkg::A_SP:    addr = sp;
      pm0_pkg::A_SP_P1: addr = sp + AW'(1);
      pm0_pkg::A_SP_M1: addr = sp - AW'(1);
      pm0_pkg::A_SP_M2: addr = sp - AW'(2);
      pm0_pkg::A_SP_M3: addr = sp - AW'(3);
      pm0_pkg::A_BP_M1: addr = bp - AW'(1);
      pm0_pkg::A_BP_M2: addr = bp - AW'(2);
      pm0_pkg::A_WALK:  addr = walk;
      pm0_pkg::A_FRAME: addr = frame;
      pm0_pkg::A_CLR:   addr = clr;
      default:          addr = sp;
    endcase
  end

  always_comb begin
    case (operand)
      pm0_pkg::OPR_ADD: alu = a + b;
      pm0_pkg::OPR_SUB: alu = a - b;
      pm0_pkg::OPR_MUL: alu = a * b;
      pm0_pkg::OPR_DIV: alu = (b == '0) ? '0 : quo;
      pm0_pkg::OPR_EQL: alu = {31'd0, a == b};
      pm0_pkg::OPR_NEQ: alu = {31'd0, a != b};
      pm0_pkg::OPR_LSS: alu = {31'd0, sa_lt};
      pm0_pkg::OPR_LEQ: alu = {31'd0, sa_lt || a == b};
      pm0_pkg::OPR_GTR: alu = {31'd0, !sa_lt && a != b};
      pm0_pkg::OPR_GEQ: alu = {31'd0, !sa_lt};
      default:          alu = 32'd0 - b;
    endcase
  end

  always_comb begin
    case (cmd.wdata)
      pm0_pkg::D_OPA:  wdata = a;
      pm0_pkg::D_ALU:  wdata = alu;
      pm0_pkg::D_BP:   wdata = 32'(bp);
      pm0_pkg::D_PC:   wdata = 32'(pc3);
      pm0_pkg::D_WALK: wdata = 32'(walk);
      pm0_pkg::D_READ: wdata = rdv;
      pm0_pkg::D_OPND: wdata = operand;
      default:         wdata = '0;
    endcase
  end

  assign stat.opcode   = opcode;
  assign stat.lvl_zero = (lvl == '0);
  assign stat.halted   = halted;
  assign stat.clr_done = clr_done;
  assign stat.div_done = div_done;
  assign stat.opr_rtn  = (operand == pm0_pkg::OPR_RTN);
  assign stat.opr_neg  = (operand == pm0_pkg::OPR_NEG);
  assign stat.opr_bin  = (operand >= pm0_pkg::OPR_ADD) && (operand <= pm0_pkg::OPR_GEQ);
  assign stat.opr_div  = (operand == pm0_pkg::OPR_DIV);
  assign stat.sys_out  = (operand == pm0_pkg::SYS_OUT);
  assign stat.sys_in   = (operand == pm0_pkg::SYS_IN);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      opcode  <= in_opcode;
      operand <= in_operand;
      rdv     <= in_read;
      lvl     <= (LW'(in_level) > LW'(MAX_LEVEL)) ? LW'(MAX_LEVEL) : LW'(in_level);
    end else if (cmd.lvl_dec) begin
      lvl <= lvl - LW'(1);
    end
    if (cmd.ld_a) a <= rdata;
    if (cmd.ld_b) b <= rdata;
    if (cmd.walk_init) walk <= bp;
    else if (cmd.ld_walk) walk <= rdata[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= '0;
      bp       <= RBP;
      sp       <= RSP;
      halted   <= 1'b0;
      clr      <= '0;
      clr_done <= 1'b0;
    end else begin
      if (cmd.clr_inc) begin
        clr <= clr + AW'(1);
        if (clr == AW'(MEM_DEPTH - 1)) clr_done <= 1'b1;
      end
      if (cmd.commit) begin
        r_pvalid <= 1'b0;
        r_pvalue <= '0;
        r_status <= pm0_pkg::ST_RUN;
        if (halted) begin
          r_status <= pm0_pkg::ST_HALT;
        end else begin
          pc <= pc3;
          case (opcode)
            pm0_pkg::OP_LIT, pm0_pkg::OP_LOD: sp <= sp - AW'(1);
            pm0_pkg::OP_OPR: begin
              if (stat.opr_rtn) begin
                bp <= a[AW-1:0];
                pc <= b[AW-1:0];
                sp <= bp + AW'(1);
              end else if (stat.opr_bin) begin
                sp <= sp + AW'(1);
                if (stat.opr_div && b == '0) r_status <= pm0_pkg::ST_DIV0;
              end
            end
            pm0_pkg::OP_STO: sp <= sp + AW'(1);
            pm0_pkg::OP_CAL: begin
              bp <= sp - AW'(1);
              pc <= m_w;
            end
            pm0_pkg::OP_INC: sp <= sp - m_w;
            pm0_pkg::OP_JMP: pc <= m_w;
            pm0_pkg::OP_JPC: begin
              if (a == '0) pc <= m_w;
              sp <= sp + AW'(1);
            end
            pm0_pkg::OP_SYS: begin
              if (stat.sys_out) begin
                r_pvalid <= 1'b1;
                r_pvalue <= a;
                sp <= sp + AW'(1);
              end else if (stat.sys_in) begin
                sp <= sp - AW'(1);
              end else if (operand == pm0_pkg::SYS_HLT) begin
                halted   <= 1'b1;
                r_status <= pm0_pkg::ST_HALT;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  // result pointers use the post-commit register values
  assign r_pc = 9'(pc);
  assign r_bp = 9'(bp);
  assign r_sp = 9'(sp);
endmodule

// ----- sv/pm0_ctrl.sv -----
// Controller state machine sequencing one instruction.
module pm0_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  pm0_pkg::pm0_stat_t stat,
  output pm0_pkg::pm0_cmd_t  cmd
);
  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_DEC   = 11'b00000000100,
    S_WALK  = 11'b00000001000,
    S_WWAIT = 11'b00000010000,
    S_RDA   = 11'b00000100000,
    S_RDB   = 11'b00001000000,
    S_DIV   = 11'b00010000000,
    S_WR    = 11'b00100000000,
    S_CAL2  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic [1:0] ph, ph_next;

  logic is_walk;
  assign is_walk = stat.opcode == pm0_pkg::OP_LOD || stat.opcode == pm0_pkg::OP_STO ||
                   stat.opcode == pm0_pkg::OP_CAL;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ph        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      ph    <= ph_next;
      if (cmd.commit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    cmd = '0;
    cmd.addr  = pm0_pkg::A_SP;
    cmd.wdata = pm0_pkg::D_ZERO;
    state_next = state;
    ph_next = ph;
    case (state)
      S_CLEAR: begin
        cmd.addr = pm0_pkg::A_CLR;
        cmd.wr = 1'b1;
        cmd.clr_inc = 1'b1;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.walk_init = 1'b1;
        ph_next = '0;
        if (in_valid && in_ready) begin
          cmd.capture = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.halted) state_next = S_DONE;
        else if (is_walk) state_next = S_WALK;
        else state_next = S_RDA;
      end
      S_WALK: begin
        if (stat.lvl_zero) begin
          state_next = S_RDA;
        end else begin
          cmd.addr = pm0_pkg::A_WALK;
          state_next = S_WWAIT;
        end
      end
      S_WWAIT: begin
        cmd.ld_walk = 1'b1;
        cmd.lvl_dec = 1'b1;
        state_next = S_WALK;
      end
      // issue read A
      S_RDA: begin
        cmd.rd = 1'b1;
        case (stat.opcode)
          pm0_pkg::OP_LOD: cmd.addr = pm0_pkg::A_FRAME;
          pm0_pkg::OP_OPR: cmd.addr = stat.opr_rtn ? pm0_pkg::A_BP_M1 :
                                      stat.opr_neg ? pm0_pkg::A_SP : pm0_pkg::A_SP_P1;
          default:         cmd.addr = pm0_pkg::A_SP;
        endcase
        state_next = S_RDB;
        ph_next = '0;
      end
      S_RDB: begin
        if (ph == 2'd0) begin
          cmd.ld_a = 1'b1;
          cmd.ld_b = 1'b1;
          cmd.addr = stat.opr_rtn ? pm0_pkg::A_BP_M2 : pm0_pkg::A_SP;
          ph_next = 2'd1;
        end else begin
          if (stat.opcode == pm0_pkg::OP_OPR && (stat.opr_rtn || stat.opr_bin))
            cmd.ld_b = 1'b1;
          if (stat.opcode == pm0_pkg::OP_OPR && stat.opr_div) begin
            cmd.div_start = 1'b1;
            state_next = S_DIV;
          end else begin
            state_next = S_WR;
          end
          ph_next = '0;
        end
      end
      S_DIV: begin
        if (stat.div_done) state_next = S_WR;
      end
      S_WR: begin
        state_next = S_DONE;
        case (stat.opcode)
          pm0_pkg::OP_LIT: begin
            cmd.wr = 1'b1; cmd.addr = pm0_pkg::A_SP_M1; cmd.wdata = pm0_pkg::D_OPND;
          end
          pm0_pkg::OP_LOD: begin
            cmd.wr = 1'b1; cmd.addr = pm0_pkg::A_SP_M1; cmd.wdata = pm0_pkg::D_OPA;
          end
          pm0_pkg::OP_STO: begin
            cmd.wr = 1'b1; cmd.addr = pm0_pkg::A_FRAME; cmd.wdata = pm0_pkg::D_OPA;
          end
          pm0_pkg::OP_OPR: begin
            if (stat.opr_neg) begin
              cmd.wr = 1'b1; cmd.addr = pm0_pkg::A_SP; cmd.wdata = pm0_pkg::D_ALU;
            end else if (stat.opr_bin) begin
              cmd.wr = 1'b1; cmd.addr = pm0_pkg::A_SP_P1; cmd.wdata = pm0_pkg::D_ALU;
            end
          end
          pm0_pkg::OP_CAL: begin
            cmd.wr = 1'b1; cmd.addr = pm0_pkg::A_SP_M1; cmd.wdata = pm0_pkg::D_WALK;
            state_next = S_CAL2;
            ph_next = '0;
          end
          pm0_pkg::OP_SYS: begin
            if (stat.sys_in) begin
              cmd.wr = 1'b1; cmd.addr = pm0_pkg::A_SP_M1; cmd.wdata = pm0_pkg::D_READ;
            end
          end
          default: ;
        endcase
      end
      S_CAL2: begin
        cmd.wr = 1'b1;
        if (ph == 2'd0) begin
          cmd.addr = pm0_pkg::A_SP_M2; cmd.wdata = pm0_pkg::D_BP;
          ph_next = 2'd1;
        end else begin
          cmd.addr = pm0_pkg::A_SP_M3; cmd.wdata = pm0_pkg::D_PC;
          state_next = S_DONE;
        end
      end
      // wait here while the previous result is still held
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ----- sv/pm0_stack_machine_execute.sv -----
// Top level: PM/0 stack machine, one instruction per input transaction.
// A new instruction is accepted only after the previous one has committed
// its result. LOD, STO and CAL first follow the static links (level clamped
// to MAX_LEVEL), CAL then makes its link writes, and DIV waits for the
// bit-serial divider; all work goes through the single stack memory port.
// After reset the memory is cleared before the first transaction is taken.
// A new instruction is accepted while a result waits, but it does not
// finish until that result has been taken.
module pm0_stack_machine_execute #(
  parameter int MEM_DEPTH = 512,
  parameter int MAX_LEVEL = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // opcode, level, operand, read_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata   // next_pc, frame_base, stack_top, print_valid,
                                // print_value, status
);
  pm0_pkg::pm0_cmd_t  cmd;
  pm0_pkg::pm0_stat_t stat;
  logic [8:0]  r_pc, r_bp, r_sp;
  logic        r_pvalid;
  logic [31:0] r_pvalue;
  logic [1:0]  r_status;

  pm0_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready), .stat(stat), .cmd(cmd));

  pm0_datapath #(.MEM_DEPTH(MEM_DEPTH), .MAX_LEVEL(MAX_LEVEL)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_opcode(s_tdata[3:0]), .in_level(s_tdata[7:4]),
    .in_operand(s_tdata[39:8]), .in_read(s_tdata[71:40]),
    .r_pc(r_pc), .r_bp(r_bp), .r_sp(r_sp), .r_pvalid(r_pvalid),
    .r_pvalue(r_pvalue), .r_status(r_status));

  assign m_tdata = {2'd0, r_status, r_pvalue, r_pvalid, r_sp, r_bp, r_pc};

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !m_tvalid || m_tready) else $error("result overwritten");
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while waiting");
  a_commit_once: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> !cmd.commit) else $error("double commit");
endmodule

// ----- tb/pm0_exec_checker.sv -----
// Checker: predicts PM/0 execute results from accepted instructions and compares them.
module pm0_exec_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] print_value;
    logic        print_valid;
    logic [8:0]  stack_top;
    logic [8:0]  frame_base;
    logic [8:0]  next_pc;
  } pm0_result_t;

  logic [31:0] stack_mem [512];
  logic [8:0]  pc, bp, sp;
  logic        halted;
  pm0_result_t results_due[$];

  initial begin
    errors  = 0;
    pending = 0;
    foreach (stack_mem[i]) stack_mem[i] = '0;
    pc = '0;
    bp = 9'(pm0_pkg::RESET_BP);
    sp = 9'(pm0_pkg::RESET_SP);
    halted = 1'b0;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [8:0] frame_at(input logic [3:0] lev);
    logic [8:0] b;
    b = bp;
    for (int i = 0; i < lev; i++) b = stack_mem[b][8:0];
    return b;
  endfunction

  task automatic execute(input logic [71:0] d);
    logic [3:0]  op;
    logic [3:0]  lev;
    logic signed [31:0] m;
    logic [31:0] rdv;
    logic [8:0]  b, below, src, f;
    logic signed [31:0] a, c;
    logic [31:0] r;
    pm0_result_t res;
    op  = d[3:0];
    lev = d[7:4];
    m   = d[39:8];
    rdv = d[71:40];
    res = '0;
    if (halted) begin
      res.status = pm0_pkg::ST_HALT;
    end else begin
      pc = pc + 9'd3;
      case (op)
        pm0_pkg::OP_LIT: begin
          sp = sp - 1'b1;
          stack_mem[sp] = m;
        end
        pm0_pkg::OP_OPR: begin
          if (m == pm0_pkg::OPR_RTN) begin
            b  = bp;
            bp = stack_mem[b - 1'b1][8:0];
            pc = stack_mem[b - 2'd2][8:0];
            sp = b + 1'b1;
          end else if (m == pm0_pkg::OPR_NEG) begin
            stack_mem[sp] = -stack_mem[sp];
          end else if (m >= signed'(pm0_pkg::OPR_ADD) && m <= signed'(pm0_pkg::OPR_GEQ)) begin
            below = sp + 1'b1;
            a = stack_mem[below];
            c = stack_mem[sp];
            r = '0;
            case (m)
              pm0_pkg::OPR_ADD: r = a + c;
              pm0_pkg::OPR_SUB: r = a - c;
              pm0_pkg::OPR_MUL: r = a * c;
              pm0_pkg::OPR_DIV: begin
                if (c == 0) begin
                  r = '0;
                  res.status = pm0_pkg::ST_DIV0;
                end else if (a == 32'sh8000_0000 && c == -1) r = a;
                else r = a / c;
              end
              pm0_pkg::OPR_EQL: r = 32'(a == c);
              pm0_pkg::OPR_NEQ: r = 32'(a != c);
              pm0_pkg::OPR_LSS: r = 32'(a < c);
              pm0_pkg::OPR_LEQ: r = 32'(a <= c);
              pm0_pkg::OPR_GTR: r = 32'(a > c);
              default: r = 32'(a >= c);
            endcase
            stack_mem[below] = r;
            sp = below;
          end
        end
        pm0_pkg::OP_LOD: begin
          src = frame_at(lev) - m[8:0];
          sp = sp - 1'b1;
          stack_mem[sp] = stack_mem[src];
        end
        pm0_pkg::OP_STO: begin
          stack_mem[frame_at(lev) - m[8:0]] = stack_mem[sp];
          sp = sp + 1'b1;
        end
        pm0_pkg::OP_CAL: begin
          f = frame_at(lev);
          stack_mem[sp - 1'b1] = 32'(f);
          stack_mem[sp - 2'd2] = 32'(bp);
          stack_mem[sp - 2'd3] = 32'(pc);
          bp = sp - 1'b1;
          pc = m[8:0];
        end
        pm0_pkg::OP_INC: sp = sp - m[8:0];
        pm0_pkg::OP_JMP: pc = m[8:0];
        pm0_pkg::OP_JPC: begin
          if (stack_mem[sp] == 0) pc = m[8:0];
          sp = sp + 1'b1;
        end
        pm0_pkg::OP_SYS: begin
          if (m == pm0_pkg::SYS_OUT) begin
            res.print_value = stack_mem[sp];
            res.print_valid = 1'b1;
            sp = sp + 1'b1;
          end else if (m == pm0_pkg::SYS_IN) begin
            sp = sp - 1'b1;
            stack_mem[sp] = rdv;
          end else if (m == pm0_pkg::SYS_HLT) begin
            halted = 1'b1;
            res.status = pm0_pkg::ST_HALT;
          end
        end
        default: ;
      endcase
    end
    res.next_pc    = pc;
    res.frame_base = bp;
    res.stack_top  = sp;
    results_due.push_back(res);
  endtask

  always @(posedge clk) begin
    pm0_result_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[61:0];
        if (results_due.size() == 0) begin
          report("unexpected transaction", m_tdata[31:0], '0);
        end else begin
          want = results_due.pop_front();
          if (got.next_pc != want.next_pc)
            report("next_pc", 32'(got.next_pc), 32'(want.next_pc));
          if (got.frame_base != want.frame_base)
            report("frame_base", 32'(got.frame_base), 32'(want.frame_base));
          if (got.stack_top != want.stack_top)
            report("stack_top", 32'(got.stack_top), 32'(want.stack_top));
          if (got.print_valid != want.print_valid)
            report("print_valid", 32'(got.print_valid), 32'(want.print_valid));
          if (got.print_value != want.print_value)
            report("print_value", got.print_value, want.print_value);
          if (got.status != want.status)
            report("status", 32'(got.status), 32'(want.status));
          if (m_tdata[63:62] != 2'b00) report("pad bits", 32'(m_tdata[63:62]), '0);
        end
      end
      if (s_tvalid && s_tready) execute(s_tdata);
      pending = results_due.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top: drives PM/0 instruction stimulus and gives the verdict.
module tb_top;

  localparam int LIMIT = 500000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;   // opcode, level, operand, read_value
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // next_pc, frame_base, stack_top, print_valid,
                               // print_value, status
  int errors, pending;
  int tx_idle = 14, rx_idle = 87, phase = 0;
  int cycles = 0;

  pm0_stack_machine_execute dut (.*);

  pm0_exec_checker chk (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver; one long hold-off when the sender runs without gaps
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (phase == 2 && !held) begin
        held = 1;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  task automatic send(input logic [3:0] op, input logic [3:0] lev,
                      input logic [31:0] opnd, input logic [31:0] rdv);
    while ($urandom_range(99) < tx_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rdv, opnd, lev, op};
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [31:0] some_val();
    case ($urandom_range(3))
      0: return $urandom_range(0, 5);
      1: return -$urandom_range(1, 5);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] offset_val();
    return ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(0, 10)) - 32'd3;
  endfunction

  task automatic random_item();
    logic [3:0]  lev;
    logic [31:0] m;
    lev = ($urandom_range(7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
    case ($urandom_range(99)) inside
      [0:21]:  send(pm0_pkg::OP_LIT, 4'($urandom), some_val(), $urandom);
      [22:46]: begin
        m = ($urandom_range(15) == 0) ? $urandom : 32'($urandom_range(1, 11));
        send(pm0_pkg::OP_OPR, 4'($urandom), m, $urandom);
      end
      [47:56]: send(pm0_pkg::OP_LOD, lev, offset_val(), $urandom);
      [57:64]: send(pm0_pkg::OP_STO, lev, offset_val(), $urandom);
      [65:68]: send(pm0_pkg::OP_INC, lev, 32'($urandom_range(0, 8)) - 32'd4, $urandom);
      [69:73]: send(pm0_pkg::OP_JMP, lev, some_val(), $urandom);
      [74:79]: send(pm0_pkg::OP_JPC, lev, some_val(), $urandom);
      [80:91]: begin
        m = ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(1, 2));
        if (m == pm0_pkg::SYS_HLT) m = 32'd4;
        send(pm0_pkg::OP_SYS, lev, m, $urandom);
      end
      [92:95]: send(4'($urandom_range(10, 15)), lev, $urandom, $urandom);
      default: send(4'd0, lev, $urandom, $urandom);
    endcase
  endtask

  // procedure call with locals, body and return
  task automatic call_frame();
    send(pm0_pkg::OP_CAL, 4'($urandom_range(0, 2)), $urandom_range(0, 511), $urandom);
    send(pm0_pkg::OP_INC, 4'd0, 32'd4, $urandom);
    send(pm0_pkg::OP_LIT, 4'd0, some_val(), $urandom);
    send(pm0_pkg::OP_STO, 4'd0, 32'd2, $urandom);
    send(pm0_pkg::OP_LOD, 4'($urandom_range(0, 3)), $urandom_range(0, 3), $urandom);
    send(pm0_pkg::OP_LOD, 4'd1, 32'd2, $urandom);
    send(pm0_pkg::OP_OPR, 4'd0, $urandom_range(2, 11), $urandom);
    send(pm0_pkg::OP_SYS, 4'd0, pm0_pkg::SYS_OUT, $urandom);
    send(pm0_pkg::OP_OPR, 4'd0, pm0_pkg::OPR_RTN, $urandom);
  endtask

  task automatic random_phase(input int n);
    int k;
    k = 0;
    while (k < n) begin
      if ($urandom_range(4) == 0) begin
        call_frame();
        k += 9;
      end else begin
        random_item();
        k++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // directed corners
    send(pm0_pkg::OP_LIT, 4'hF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send(pm0_pkg::OP_LIT, 4'd0, 32'h8000_0000, 32'h0);
    send(pm0_pkg::OP_OPR, 4'd0, pm0_pkg::OPR_ADD, 32'h0);
    send(pm0_pkg::OP_LIT, 4'd0, 32'd0, 32'h0);
    send(pm0_pkg::OP_OPR, 4'd0, pm0_pkg::OPR_DIV, 32'h0);
    send(pm0_pkg::OP_LIT, 4'd0, 32'h8000_0000, 32'h0);
    send(pm0_pkg::OP_LIT, 4'd0, 32'hFFFF_FFFF, 32'h0);
    send(pm0_pkg::OP_OPR, 4'd0, pm0_pkg::OPR_DIV, 32'h0);
    send(pm0_pkg::OP_OPR, 4'd0, pm0_pkg::OPR_NEG, 32'h0);
    send(pm0_pkg::OP_LIT, 4'd0, -32'sd7, 32'h0);
    send(pm0_pkg::OP_OPR, 4'd0, pm0_pkg::OPR_MUL, 32'h0);
    send(pm0_pkg::OP_LIT, 4'd0, 32'd3, 32'h0);
    send(pm0_pkg::OP_OPR, 4'd0, pm0_pkg::OPR_SUB, 32'h0);
    send(pm0_pkg::OP_SYS, 4'd0, pm0_pkg::SYS_IN, 32'h8000_0001);
    send(pm0_pkg::OP_OPR, 4'd0, pm0_pkg::OPR_LSS, 32'h0);
    send(pm0_pkg::OP_CAL, 4'd0, 32'hFFFF_FFFD, 32'h0);
    send(pm0_pkg::OP_INC, 4'd0, 32'd5, 32'h0);
    send(pm0_pkg::OP_STO, 4'hF, 32'hFFFF_FFFF, 32'h0);
    send(pm0_pkg::OP_LOD, 4'hF, 32'h7FFF_FFFF, 32'h0);
    send(pm0_pkg::OP_JPC, 4'd0, 32'd40, 32'h0);
    send(pm0_pkg::OP_JMP, 4'd0, -32'sd1, 32'h0);
    send(pm0_pkg::OP_SYS, 4'd0, pm0_pkg::SYS_OUT, 32'h0);
    send(pm0_pkg::OP_OPR, 4'd0, pm0_pkg::OPR_RTN, 32'h0);
    send(4'hF, 4'd0, 32'd0, 32'h0);
    send(pm0_pkg::OP_OPR, 4'd0, 32'd99, 32'h0);
    send(pm0_pkg::OP_SYS, 4'd0, 32'd7, 32'h0);
    random_phase(130);
    tx_idle = 87;
    rx_idle = 14;
    phase = 1;
    random_phase(130);
    tx_idle = 0;
    rx_idle = 0;
    phase = 2;
    random_phase(60);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    random_phase(70);
    send(pm0_pkg::OP_SYS, 4'd0, pm0_pkg::SYS_HLT, 32'h0);
    send(pm0_pkg::OP_LIT, 4'd0, 32'd1, 32'h0);
    send(pm0_pkg::OP_SYS, 4'd0, pm0_pkg::SYS_OUT, 32'h0);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
